>>> design/first_fit_heap_allocator_macros.svh
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFHA_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define FFHA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FFHA_ASSERT_IMPL(label, clk, rst, a, c)
`define FFHA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> design/ffha_pkg.sv
package ffha_pkg;
  localparam int HEAP_WORDS = 8192;
  localparam int INITIAL_REGION_BYTES = 1024;
  localparam int AW = $clog2(HEAP_WORDS);
  localparam logic [31:0] REGION = 32'(INITIAL_REGION_BYTES) & ~32'h7;
  localparam logic [31:0] CAP = (HEAP_WORDS * 8 < 65536) ? 32'(HEAP_WORDS * 8) : 32'd65536;
  localparam logic [31:0] MIN_BLK = 32'd32;
  localparam logic [31:0] TAG = 32'd8;
  localparam logic [31:0] MAX_STEPS = 32'(HEAP_WORDS);

  typedef enum logic [1:0] {
    ALU_NONE, ALU_SET, ALU_CLR
  } alu_t;

  // command from controller to datapath
  typedef struct packed {
    logic        rd_en;
    logic [31:0] rd_addr;
    logic        wr_en;
    logic [31:0] wr_addr;
    logic [31:0] wr_data;
  } mem_cmd_t;

  function automatic logic [AW-1:0] slot(input logic [31:0] off);
    slot = off[AW+2:3];
  endfunction
endpackage

>>> design/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/ffha_datapath.sv
module ffha_datapath (
  input  logic              clk,
  input  ffha_pkg::mem_cmd_t cmd,
  output logic [31:0]       rdata
);
  ffha_ram #(.WIDTH(32), .DEPTH(ffha_pkg::HEAP_WORDS)) u_ram (
    .clk(clk),
    .we(cmd.wr_en),
    .waddr(ffha_pkg::slot(cmd.wr_addr)),
    .wdata(cmd.wr_data),
    .raddr(ffha_pkg::slot(cmd.rd_addr)),
    .rdata(rdata)
  );
endmodule

>>> design/ffha_ctrl.sv
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [15:0]        request_size,
  input  logic [15:0]        free_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        payload_offset,
  output logic               status,
  output ffha_pkg::mem_cmd_t cmd,
  input  logic [31:0]        rdata,
  output logic               busy
);
  // Micro-op sequencer: each read has an issue state followed by a wait state.
  typedef enum logic [5:0] {
    S_CLEAR, S_INIT, S_IDLE,
    M_RHDR, M_WHDR, M_RPF, M_WPF, M_RNH, M_WNH, M_DEC,
    M_UL_RN, M_UL_WN, M_UL_RP, M_UL_WP, M_UL_W1, M_UL_W2, M_UL_RET,
    M_ST1, M_ST2, M_PU_R, M_PU_W, M_PU_W1, M_PU_W2, M_PU_W3, M_PU_W4,
    M_CF_R, M_CF_W, M_CF_W2,
    F_RFIRST, F_WFIRST, F_RHDR, F_WHDR, F_RNX, F_WNX, F_FOUND, F_RFT, F_WFT, F_WFT2,
    A_GROW, A_G1, A_G2, A_G3, A_RB, A_WB, A_SPLIT, A_S1, A_S2, A_S3, A_S4, A_DONE,
    S_OUT
  } state_t;

  localparam int AW_C = ffha_pkg::AW;

  state_t      st;
  state_t      ret, ul_ret;
  logic [31:0] b, bsize, hdr, pf, nh, pb, nx, pv, first, asize, blk, steps, ul_b, t;
  logic [31:0] heap_top, end_mark;
  logic [AW_C-1:0] clr;

  assign in_ready = (st == S_IDLE);
  assign busy = (st != S_IDLE);

  always_ff @(posedge clk) begin
    cmd.rd_en <= 1'b0;
    cmd.wr_en <= 1'b0;
    if (rst) begin
      st <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      heap_top <= ffha_pkg::REGION + 32'd48;
      end_mark <= ffha_pkg::REGION + 32'd32;
    end else begin
      unique case (st)
        S_CLEAR: begin
          cmd.wr_en <= 1'b1;
          cmd.wr_addr <= {{(29-AW_C){1'b0}}, clr, 3'b0};
          cmd.wr_data <= '0;
          clr <= clr + 1'b1;
          if (&clr) begin
            st <= S_INIT;
            t <= '0;
          end
        end
        S_INIT: begin
          cmd.wr_en <= 1'b1;
          t <= t + 1;
          unique case (t[2:0])
            3'd0: begin cmd.wr_addr <= 32'd0; cmd.wr_data <= 32'd1; end
            3'd1: begin cmd.wr_addr <= 32'd8; cmd.wr_data <= 32'd32; end
            3'd2: begin cmd.wr_addr <= 32'd16; cmd.wr_data <= 32'd32; end
            3'd3: begin cmd.wr_addr <= 32'd24; cmd.wr_data <= 32'd1; end
            3'd4: begin cmd.wr_addr <= 32'd32; cmd.wr_data <= ffha_pkg::REGION; end
            3'd5: begin
              cmd.wr_addr <= 32'd24 + ffha_pkg::REGION; cmd.wr_data <= ffha_pkg::REGION;
            end
            3'd6: begin cmd.wr_addr <= 32'd40; cmd.wr_data <= 32'd0; end
            default: begin
              cmd.wr_addr <= 32'd32 + ffha_pkg::REGION; cmd.wr_data <= 32'd1;
              st <= S_IDLE;
            end
          endcase
        end
        S_IDLE: begin
          if (in_valid) begin
            payload_offset <= '0;
            status <= 1'b0;
            if (func) begin
              b <= {16'd0, free_offset} - ffha_pkg::TAG;
              ret <= S_OUT;
              st <= M_RHDR;
            end else begin
              asize <= ({16'd0, request_size} + 32'd47) & ~32'h7;
              steps <= '0;
              st <= F_RFIRST;
            end
          end
        end
        // ---- merge_free(b), returns to ret
        M_RHDR: begin cmd.rd_en <= 1'b1; cmd.rd_addr <= b; st <= M_WHDR; end
        M_WHDR: st <= M_RPF;
        M_RPF: begin
          hdr <= rdata; bsize <= rdata & ~32'h7;
          cmd.rd_en <= 1'b1; cmd.rd_addr <= b - ffha_pkg::TAG; st <= M_WPF;
        end
        M_WPF: st <= M_RNH;
        M_RNH: begin
          pf <= rdata;
          cmd.rd_en <= 1'b1; cmd.rd_addr <= b + bsize; st <= M_WNH;
        end
        M_WNH: st <= M_DEC;
        M_DEC: begin
          nh <= rdata;
          if (!pf[0]) begin
            pb <= b - (pf & ~32'h7);
            ul_b <= b - (pf & ~32'h7);
            bsize <= bsize + (pf & ~32'h7);
            ul_ret <= M_ST1;
            st <= M_UL_RN;
          end else if (!rdata[0]) begin
            pb <= b;
            ul_b <= b + bsize;
            bsize <= bsize + (rdata & ~32'h7);
            ul_ret <= M_ST2;
            st <= M_UL_RN;
          end else begin
            pb <= b;
            cmd.wr_en <= 1'b1; cmd.wr_addr <= b; cmd.wr_data <= hdr & ~32'h1;
            cmd.rd_en <= 1'b1; cmd.rd_addr <= b + bsize - ffha_pkg::TAG;
            st <= M_CF_R;
          end
        end
        M_CF_R: st <= M_CF_W;
        M_CF_W: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= b + bsize - ffha_pkg::TAG;
          cmd.wr_data <= rdata & ~32'h1;
          st <= M_PU_R;
        end
        M_ST1: begin
          if (!nh[0]) begin
            ul_b <= b + (hdr & ~32'h7);
            bsize <= bsize + (nh & ~32'h7);
            ul_ret <= M_ST2;
            st <= M_UL_RN;
          end else begin
            st <= M_ST2;
          end
        end
        M_ST2: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= pb; cmd.wr_data <= bsize;
          st <= M_CF_W2;
        end
        M_CF_W2: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= pb + bsize - ffha_pkg::TAG; cmd.wr_data <= bsize;
          st <= M_PU_R;
        end
        M_PU_R: begin cmd.rd_en <= 1'b1; cmd.rd_addr <= 32'd8; st <= M_PU_W; end
        M_PU_W: st <= M_PU_W1;
        M_PU_W1: begin
          first <= rdata;
          cmd.wr_en <= 1'b1; cmd.wr_addr <= pb + 32'd8; cmd.wr_data <= rdata;
          st <= M_PU_W2;
        end
        M_PU_W2: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= pb + 32'd16; cmd.wr_data <= '0;
          st <= M_PU_W3;
        end
        M_PU_W3: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= first + 32'd16; cmd.wr_data <= pb;
          st <= M_PU_W4;
        end
        M_PU_W4: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= 32'd8; cmd.wr_data <= pb;
          st <= ret;
        end
        // ---- unlink(ul_b), returns to ul_ret
        M_UL_RN: begin cmd.rd_en <= 1'b1; cmd.rd_addr <= ul_b + 32'd8; st <= M_UL_WN; end
        M_UL_WN: st <= M_UL_RP;
        M_UL_RP: begin
          nx <= rdata;
          cmd.rd_en <= 1'b1; cmd.rd_addr <= ul_b + 32'd16; st <= M_UL_WP;
        end
        M_UL_WP: st <= M_UL_W1;
        M_UL_W1: begin
          pv <= rdata;
          cmd.wr_en <= 1'b1; cmd.wr_addr <= rdata + 32'd8; cmd.wr_data <= nx;
          st <= M_UL_W2;
        end
        M_UL_W2: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= nx + 32'd16; cmd.wr_data <= pv;
          st <= ul_ret;
        end
        M_UL_RET: st <= ul_ret;
        // ---- first fit
        F_RFIRST: begin cmd.rd_en <= 1'b1; cmd.rd_addr <= 32'd8; st <= F_WFIRST; end
        F_WFIRST: st <= F_RHDR;
        F_RHDR: begin
          b <= rdata;
          if (steps >= ffha_pkg::MAX_STEPS || rdata == '0) begin
            st <= A_GROW;
          end else begin
            cmd.rd_en <= 1'b1; cmd.rd_addr <= rdata; st <= F_WHDR;
          end
        end
        F_WHDR: st <= F_RNX;
        F_RNX: begin
          hdr <= rdata;
          if (!rdata[0] && (rdata & ~32'h7) >= asize) begin
            ul_b <= b; ul_ret <= F_FOUND; st <= M_UL_RN;
          end else begin
            cmd.rd_en <= 1'b1; cmd.rd_addr <= b + 32'd8; st <= F_WNX;
            steps <= steps + 1;
          end
        end
        F_WNX: st <= F_RHDR;
        F_FOUND: begin
          blk <= b;
          cmd.wr_en <= 1'b1; cmd.wr_addr <= b; cmd.wr_data <= hdr | 32'h1;
          cmd.rd_en <= 1'b1; cmd.rd_addr <= b + (hdr & ~32'h7) - ffha_pkg::TAG;
          st <= F_RFT;
        end
        F_RFT: st <= F_WFT;
        F_WFT: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= blk + (hdr & ~32'h7) - ffha_pkg::TAG;
          cmd.wr_data <= rdata | 32'h1;
          st <= F_WFT2;
        end
        F_WFT2: st <= A_RB;
        // ---- grow
        A_GROW: begin
          if (heap_top + asize > ffha_pkg::CAP) begin
            status <= 1'b1; st <= S_OUT;
          end else begin
            blk <= end_mark;
            cmd.wr_en <= 1'b1; cmd.wr_addr <= end_mark; cmd.wr_data <= asize | 32'h1;
            st <= A_G1;
          end
        end
        A_G1: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= blk + asize - ffha_pkg::TAG;
          cmd.wr_data <= asize | 32'h1;
          end_mark <= (blk + asize) & 32'h1FFFF;
          st <= A_G2;
        end
        A_G2: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= end_mark; cmd.wr_data <= 32'd1;
          heap_top <= (heap_top + asize) & 32'h1FFFF;
          st <= A_G3;
        end
        A_G3: st <= A_RB;
        A_RB: begin cmd.rd_en <= 1'b1; cmd.rd_addr <= blk; st <= A_WB; end
        A_WB: st <= A_SPLIT;
        A_SPLIT: begin
          t <= rdata & ~32'h7;
          if ((rdata & ~32'h7) >= asize + ffha_pkg::MIN_BLK) begin
            cmd.wr_en <= 1'b1; cmd.wr_addr <= blk; cmd.wr_data <= asize | 32'h1;
            st <= A_S1;
          end else begin
            st <= A_DONE;
          end
        end
        A_S1: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= blk + asize - ffha_pkg::TAG;
          cmd.wr_data <= asize | 32'h1;
          st <= A_S2;
        end
        A_S2: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= blk + asize; cmd.wr_data <= t - asize;
          st <= A_S3;
        end
        A_S3: begin
          cmd.wr_en <= 1'b1; cmd.wr_addr <= blk + t - ffha_pkg::TAG;
          cmd.wr_data <= t - asize;
          b <= blk + asize;
          ret <= A_DONE;
          st <= A_S4;
        end
        A_S4: st <= M_RHDR;
        A_DONE: begin
          payload_offset <= 16'(blk + ffha_pkg::TAG);
          st <= S_OUT;
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            st <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/first_fit_heap_allocator.sv
// First-fit heap allocator with boundary tags and a LIFO explicit free list kept
// in a single-port-read block RAM. After reset a clearing pass writes every one
// of the HEAP_WORDS slots (one per cycle) plus eight layout writes; no item is
// taken until it ends. Each memory read has an issue state and a wait state,
// and an allocate walks the free list node by node in its first-fit search, so
// its time grows with fragmentation. One item is in flight at a time.
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] request_size,
  input  logic [15:0] free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] payload_offset,
  output logic        status
);
  ffha_pkg::mem_cmd_t cmd;
  logic [31:0]        rdata;
  logic               busy;

  ffha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .request_size(request_size), .free_offset(free_offset), .out_valid(out_valid),
    .out_ready(out_ready), .payload_offset(payload_offset), .status(status),
    .cmd(cmd), .rdata(rdata), .busy(busy)
  );

  ffha_datapath u_dp (.clk(clk), .cmd(cmd), .rdata(rdata));

  `FFHA_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, !busy && !out_valid)
  `FFHA_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, busy)
  `FFHA_ASSERT_IMPL(a_oom_zero, clk, rst, out_valid && status, payload_offset == 16'd0)
endmodule
